@@ rtl/core/dated_rate_floor_lookup_top_assert.svh @@
// Assertion macros for the dated rate floor lookup block.
// Needs a clock i_clk and an active low reset i_rst_n in the including module.
`ifndef DATED_RATE_FLOOR_LOOKUP_TOP_ASSERT_SVH
`define DATED_RATE_FLOOR_LOOKUP_TOP_ASSERT_SVH

// Property that must hold at every edge out of reset
`define DRFL_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("dated rate lookup check failed");

// Implication checked at every edge out of reset
`define DRFL_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dated rate lookup check failed");

`endif

@@ rtl/core/drfl_pkg.sv @@
// Package for the dated rate floor lookup: table size, status codes, entry type
// and calendar helpers. No dependencies.
package drfl_pkg;

    localparam int TableDepth = 1024;
    localparam int IdxW       = $clog2(TableDepth);
    localparam int CntW       = $clog2(TableDepth + 1);

    localparam logic [31:0] AmountMaxQ16 = 32'd65536000;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_DATE   = 3'd1,
        ST_NEGATIVE   = 3'd2,
        ST_TOO_LARGE  = 3'd3,
        ST_NO_EARLIER = 3'd4,
        ST_FULL       = 3'd5
    } t_status;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } t_req;

    typedef struct packed {
        logic [22:0] key;
        logic [39:0] rate;
    } t_entry;

    // Leap year: divisible by 4 and (not by 25 or by 16). Mod 25 by reciprocal.
    function automatic logic is_leap(input logic [13:0] y);
        logic [26:0] prod;
        logic [9:0]  q;
        logic [14:0] qx25;
        logic [13:0] rem;
        prod = {13'd0, y} * 27'd5243;
        q    = prod[26:17];
        qx25 = {5'd0, q} * 15'd25;
        rem  = y - qx25[13:0];
        return (y[1:0] == 2'd0) && ((rem != 14'd0) || (y[3:0] == 4'd0));
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            4'd2:                    d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
            default:                 d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/core/dated_rate_floor_lookup_top.sv @@
// Dated rate floor lookup: keeps up to drfl_pkg::TableDepth (date, rate) entries
// sorted by date in one synchronous memory with a registered read, and
// handles one item at a time. An item failing the input checks answers the cycle after it is taken.
// Otherwise a binary search reads the middle entry and halves the range
// (S_SRCH, S_CHK), then checks the entry at the floor position (S_PCHK); a query
// then multiplies the amount by the floor rate (S_MUL) and sums the partial
// products (S_SUM). A load of a new key shifts every later entry up by one,
// a read (S_SHRD) and a write (S_SHWR) per entry, through the single memory
// port. The next item is taken once the result has left.
// Depends on drfl_pkg and dated_rate_floor_lookup_top_assert.svh.
`include "dated_rate_floor_lookup_top_assert.svh"

module dated_rate_floor_lookup_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [13:0] i_year,
    input  logic [6:0]  i_month,
    input  logic [6:0]  i_day,
    input  logic [39:0] i_rate_q16,
    input  logic [31:0] i_amount_q16,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [49:0] o_total_q16,
    output logic [22:0] o_matched_key
);
    import drfl_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SRCH = 8'b0000_0010,
        S_CHK  = 8'b0000_0100,
        S_PCHK = 8'b0000_1000,
        S_SHRD = 8'b0001_0000,
        S_SHWR = 8'b0010_0000,
        S_MUL  = 8'b0100_0000,
        S_SUM  = 8'b1000_0000
    } t_state;

    t_state       r_state, n_state;
    logic [CntW-1:0] r_count, n_count;
    logic [CntW-1:0] r_lo, n_lo, r_hi, n_hi, r_idx, n_idx;
    t_req         r_req, n_req;
    logic [22:0]  r_key, n_key;
    logic [39:0]  r_rate, n_rate;
    logic [25:0]  r_amt, n_amt;
    logic [49:0]  r_p_hi, n_p_hi;
    logic [41:0]  r_p_lo, n_p_lo;
    logic [22:0]  r_mkey, n_mkey;
    logic         r_o_valid, n_o_valid;
    t_status      r_status, n_status;
    logic [49:0]  r_total, n_total;
    logic [22:0]  r_matched, n_matched;

    // Table memory
    t_entry          mem [TableDepth];
    t_entry          r_rdata;
    logic            mem_re, mem_we;
    logic [IdxW-1:0] mem_ra, mem_wa;
    t_entry          mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (mem_re) r_rdata <= mem[mem_ra];
    end

    // Input checks
    logic       acc, leap, shape_ok, date_ok;
    logic [3:0] m4;
    logic [4:0] d5;
    assign acc      = i_valid && o_ready;
    assign m4       = i_month[3:0];
    assign d5       = i_day[4:0];
    assign leap     = is_leap(i_year);
    assign shape_ok = (i_month >= 7'd1) && (i_month <= 7'd12) &&
                      (i_day >= 7'd1) && (i_day <= 7'd31);
    assign date_ok  = shape_ok && (d5 <= month_days(m4, leap));

    // Search helpers
    logic [CntW:0]   lo_hi_sum;
    logic [IdxW-1:0] mid;
    logic            eq, decide;
    assign lo_hi_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid       = lo_hi_sum[IdxW:1];
    assign eq        = (r_state == S_PCHK) && (r_rdata.key == r_key);
    assign decide    = (r_state == S_PCHK) ||
                       ((r_state == S_SRCH) && !(r_lo < r_hi) && !(r_lo < r_count));

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_idx     = r_idx;
        n_req     = r_req;
        n_key     = r_key;
        n_rate    = r_rate;
        n_amt     = r_amt;
        n_p_hi    = r_p_hi;
        n_p_lo    = r_p_lo;
        n_mkey    = r_mkey;
        n_o_valid = r_o_valid;
        n_status  = r_status;
        n_total   = r_total;
        n_matched = r_matched;
        mem_re    = 1'b0;
        mem_ra    = '0;
        mem_we    = 1'b0;
        mem_wa    = r_lo[IdxW-1:0];
        mem_wd    = '{key: r_key, rate: r_rate};

        if (r_o_valid && i_ready) n_o_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_req     = t_req'(i_req_type);
                    n_key     = {i_year, m4, d5};
                    n_rate    = i_rate_q16;
                    n_amt     = i_amount_q16[25:0];
                    n_lo      = '0;
                    n_hi      = r_count;
                    n_total   = '0;
                    n_matched = '0;
                    n_state   = S_SRCH;
                    if (i_req_type == REQ_LOAD) begin
                        if (!shape_ok) begin
                            n_status  = ST_BAD_DATE;
                            n_o_valid = 1'b1;
                            n_state   = S_IDLE;
                        end
                    end else if (!date_ok) begin
                        n_status  = ST_BAD_DATE;
                        n_o_valid = 1'b1;
                        n_state   = S_IDLE;
                    end else if (i_amount_q16[31]) begin
                        n_status  = ST_NEGATIVE;
                        n_o_valid = 1'b1;
                        n_state   = S_IDLE;
                    end else if (i_amount_q16 > AmountMaxQ16) begin
                        n_status  = ST_TOO_LARGE;
                        n_o_valid = 1'b1;
                        n_state   = S_IDLE;
                    end
                end
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    mem_re  = 1'b1;
                    mem_ra  = mid;
                    n_state = S_CHK;
                end else if (r_lo < r_count) begin
                    mem_re  = 1'b1;
                    mem_ra  = r_lo[IdxW-1:0];
                    n_state = S_PCHK;
                end
            end
            S_CHK: begin
                if (r_rdata.key < r_key) n_lo = {1'b0, mid} + CntW'(1);
                else                     n_hi = {1'b0, mid};
                n_state = S_SRCH;
            end
            S_SHRD: begin
                if (r_idx == r_lo) begin
                    mem_we    = 1'b1;
                    n_count   = r_count + CntW'(1);
                    n_status  = ST_OK;
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    mem_re  = 1'b1;
                    mem_ra  = r_idx[IdxW-1:0] - IdxW'(1);
                    n_state = S_SHWR;
                end
            end
            S_SHWR: begin
                mem_we  = 1'b1;
                mem_wa  = r_idx[IdxW-1:0];
                mem_wd  = r_rdata;
                n_idx   = r_idx - CntW'(1);
                n_state = S_SHRD;
            end
            S_MUL: begin
                n_p_hi  = {24'd0, r_amt} * {26'd0, r_rdata.rate[39:16]};
                n_p_lo  = {16'd0, r_amt} * {26'd0, r_rdata.rate[15:0]};
                n_mkey  = r_rdata.key;
                n_state = S_SUM;
            end
            S_SUM: begin
                n_total   = r_p_hi + {24'd0, r_p_lo[41:16]};
                n_matched = r_mkey;
                n_status  = ST_OK;
                n_o_valid = 1'b1;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        // Floor position known: r_lo is the first key not below the item key
        if (decide) begin
            if (r_req == REQ_LOAD) begin
                if (eq) begin
                    mem_we    = 1'b1;
                    n_status  = ST_OK;
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end else if (r_count == CntW'(TableDepth)) begin
                    n_status  = ST_FULL;
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_idx   = r_count;
                    n_state = S_SHRD;
                end
            end else begin
                if (eq) begin
                    n_state = S_MUL;
                end else if (r_lo == '0) begin
                    n_status  = ST_NO_EARLIER;
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    mem_re  = 1'b1;
                    mem_ra  = r_lo[IdxW-1:0] - IdxW'(1);
                    n_state = S_MUL;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_idx     <= n_idx;
        r_req     <= n_req;
        r_key     <= n_key;
        r_rate    <= n_rate;
        r_amt     <= n_amt;
        r_p_hi    <= n_p_hi;
        r_p_lo    <= n_p_lo;
        r_mkey    <= n_mkey;
        r_status  <= n_status;
        r_total   <= n_total;
        r_matched <= n_matched;
    end

    assign o_ready       = (r_state == S_IDLE) && !r_o_valid;
    assign o_valid       = r_o_valid;
    assign o_status      = r_status;
    assign o_total_q16   = r_total;
    assign o_matched_key = r_matched;

    // Checks
    `DRFL_ASSERT_ALWAYS(a_count_bound, r_count <= CntW'(TableDepth))
    `DRFL_ASSERT_IMPLIES(a_ready_idle, o_ready, r_state == S_IDLE)
    `DRFL_ASSERT_IMPLIES(a_fail_zero, o_valid && (o_status != ST_OK),
        (o_total_q16 == '0) && (o_matched_key == '0))
    `DRFL_ASSERT_IMPLIES(a_shift_no_full, r_state == S_SHWR, r_count < CntW'(TableDepth))

endmodule
